[hw/rtl/sctu_pkg.sv]
// ----------------------------------------------------------------------------
// sctu_pkg: shared types and constants for the saturated cost table update.
// Holds the item word types, the mode codes and the table sizes.
// ----------------------------------------------------------------------------
package sctu_pkg;

  localparam int STATE_COUNT = 1024;
  localparam int NUM_OPS     = 1024;
  localparam int ST_W        = $clog2(STATE_COUNT);
  localparam int OP_W        = $clog2(NUM_OPS);
  localparam int EPOCH_W     = 8;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_LOAD  = 3'd1;
  localparam logic [2:0] MODE_SUCC  = 3'd2;
  localparam logic [2:0] MODE_SELF  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  state_index;
    logic [9:0]  op_index;
    logic [9:0]  succ_index;
    logic [16:0] probability;
    logic [30:0] dist_value;
    logic        dist_infinite;
    logic        last_outcome;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] cost_value;
    logic               cost_neg_infinite;
  } out_word_t;

  // Classified word passed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  mode;
    logic        st_ok;
    logic        op_ok;
    logic        sc_ok;
    logic [ST_W-1:0] st;
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] sc;
    logic [16:0] probability;
    logic [31:0] dist_word;
    logic        last_outcome;
  } cmd_t;

endpackage

[hw/rtl/sctu_front.sv]
// ----------------------------------------------------------------------------
// sctu_front: input stage.
// Accepts input words, checks index ranges and pushes classified commands
// into a two-entry queue that the back part drains.
// ----------------------------------------------------------------------------
module sctu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sctu_pkg::in_word_t in_word,
  input  logic              cmd_take,
  output logic              cmd_valid,
  output sctu_pkg::cmd_t    cmd
);
  import sctu_pkg::*;

  cmd_t       q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       c;
  logic       do_push, do_pop;

  // Classify the incoming word.
  always_comb begin
    c.mode         = in_word.mode;
    c.st_ok        = 32'(in_word.state_index) < STATE_COUNT;
    c.op_ok        = 32'(in_word.op_index) < NUM_OPS;
    c.sc_ok        = 32'(in_word.succ_index) < STATE_COUNT;
    c.st           = in_word.state_index[ST_W-1:0];
    c.op           = in_word.op_index[OP_W-1:0];
    c.sc           = in_word.succ_index[ST_W-1:0];
    c.probability  = in_word.probability;
    c.dist_word    = {in_word.dist_infinite, in_word.dist_value};
    c.last_outcome = in_word.last_outcome;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && cmd_valid;

  // Queue pointers.
  always_comb begin
    wr_nxt  = wr_r ^ do_push;
    rd_nxt  = rd_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= c;
    end
  end

endmodule

[hw/rtl/sctu_back.sv]
// ----------------------------------------------------------------------------
// sctu_back: table update engine.
// Sequences successor and self-loop commands through table reads, multiply,
// accumulate and cost update; reads place results in an output register.
// ----------------------------------------------------------------------------
module sctu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               general_costs,
  input  logic               cmd_valid,
  input  sctu_pkg::cmd_t     cmd,
  output logic               cmd_take,
  output logic               out_empty,
  input  logic               out_pop,
  output sctu_pkg::out_word_t out_word
);
  import sctu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [31:0]        dist_mem [STATE_COUNT];
  logic signed [31:0] cost_mem [NUM_OPS];
  logic [EPOCH_W-1:0] tag_mem  [NUM_OPS];

  logic [2:0]  state_r;
  cmd_t        c_r;
  logic [31:0] dst_r, dsc_r;
  logic signed [31:0] cost_rd_r;
  logic [EPOCH_W-1:0] tag_rd_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [OP_W-1:0]    clr_idx_r;
  logic [31:0] acc_r;
  logic        skip_r;
  logic [47:0] prod_r;
  logic        ovalid_r;
  out_word_t   ow_r;
  logic        do_succ_cost, do_self, wr_cost;
  logic        written;
  logic signed [31:0] cand, newc;
  logic [32:0] sum;
  logic        bad;

  assign cmd_take  = (state_r == S_IDLE) && !(ovalid_r && cmd_valid && cmd.mode == MODE_READ);
  assign out_empty = !ovalid_r;
  assign out_word  = ow_r;

  // Transition check and accumulator sum; a cost counts as written in this
  // run when its tag matches the current run epoch.
  always_comb begin
    bad  = !(c_r.st_ok && c_r.sc_ok && c_r.op_ok) || dst_r[31] || dsc_r[31];
    sum  = {1'b0, acc_r} + {1'b0, prod_r[47:16]};
    written = (tag_rd_r == epoch_r);
    do_succ_cost = (c_r.mode == MODE_SUCC) && c_r.last_outcome && !skip_r && !bad;
    do_self = (c_r.mode == MODE_SELF) && general_costs && c_r.st_ok && c_r.op_ok
              && !dst_r[31];
    cand = do_self ? 32'sd0 : ($signed({1'b0, dst_r[30:0]}) - $signed(acc_r));
    if (!written) begin
      newc = (general_costs || cand > 0) ? cand : 32'sd0;
    end else begin
      newc = (cand > cost_rd_r) ? cand : cost_rd_r;
    end
    wr_cost = (state_r == S_UPD) && (do_succ_cost || do_self);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
      epoch_r   <= '0;
      acc_r     <= 32'd0;
      skip_r    <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid && cmd_take) begin
            c_r <= cmd;
            case (cmd.mode)
              MODE_START: begin
                acc_r  <= 32'd0;
                skip_r <= 1'b0;
                // A new epoch forgets all written costs; the last epoch
                // value forces a clearing pass over the tags.
                if (&epoch_r) begin
                  clr_idx_r <= '0;
                  state_r   <= S_CLR;
                end else begin
                  epoch_r <= epoch_r + EPOCH_W'(1);
                end
              end
              MODE_SUCC, MODE_SELF, MODE_READ: state_r <= S_RD;
              default: ;
            endcase
          end
        end
        S_RD: state_r <= (c_r.mode == MODE_READ) ? S_UPD : S_MUL;
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          if (c_r.mode == MODE_SUCC) begin
            if (bad) skip_r <= 1'b1;
            else if (!skip_r) acc_r <= (sum[32] || sum[31]) ? ACC_MAX : sum[31:0];
          end
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (c_r.mode == MODE_READ) begin
            ovalid_r <= 1'b1;
            ow_r.cost_value <= (c_r.op_ok && written) ? cost_rd_r : 32'sd0;
            ow_r.cost_neg_infinite <= c_r.op_ok && !written && general_costs;
          end
          if (c_r.mode == MODE_SUCC && c_r.last_outcome) begin
            acc_r  <= 32'd0;
            skip_r <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        S_CLR: begin
          clr_idx_r <= clr_idx_r + OP_W'(1);
          if (clr_idx_r == OP_W'(NUM_OPS - 1)) begin
            epoch_r <= EPOCH_W'(1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Table memories; reads are registered.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid && cmd_take && cmd.mode == MODE_LOAD && cmd.st_ok) begin
      dist_mem[cmd.st] <= cmd.dist_word;
    end
    if (state_r == S_RD) begin
      dst_r     <= dist_mem[c_r.st];
      dsc_r     <= dist_mem[c_r.sc];
      cost_rd_r <= cost_mem[c_r.op];
      tag_rd_r  <= tag_mem[c_r.op];
    end
    if (wr_cost) cost_mem[c_r.op] <= newc;
    if (state_r == S_CLR) tag_mem[clr_idx_r] <= '0;
    else if (wr_cost) tag_mem[c_r.op] <= epoch_r;
  end

  // Rounded product of probability and successor distance.
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= {31'd0, c_r.probability} * {17'd0, dsc_r[30:0]} + 48'h8000;
    end
  end

endmodule

[hw/rtl/saturated_cost_table_update.sv]
// ----------------------------------------------------------------------------
// saturated_cost_table_update: saturated cost table update, top level.
// Channel  Handshake      Word
// in       push / full    in_word_t
// out      empty / pop    out_word_t
// cfg      valid / ready  general_costs bit
// Start, load and unused words are handled in the back part as they are taken;
// successor and self-loop words step through take, read, multiply, accumulate
// and update, and read words through take, read and output, in the sequencer.
// Reset is synchronous; it starts a pass that clears all 1024 cost tags,
// and every 255th start word after it triggers the same pass.
// A pending result blocks only the next read word; a two-word queue
// lets input words be taken while the back part works.
// ----------------------------------------------------------------------------
module saturated_cost_table_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  sctu_pkg::in_word_t  in_word,
  output logic                out_empty,
  input  logic                out_pop,
  output sctu_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import sctu_pkg::*;

  logic gc_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) gc_r <= 1'b0;
    else if (cfg_valid && cfg_ready) gc_r <= cfg_data;
  end

  sctu_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_word,
    .cmd_take, .cmd_valid, .cmd
  );

  sctu_back u_back (
    .clk, .rst_n, .general_costs(gc_r), .cmd_valid, .cmd, .cmd_take,
    .out_empty, .out_pop, .out_word
  );

`ifndef NO_ASSERTIONS
  // A pending result must hold while not popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_word))
    else $error("result changed while waiting");
  // Minus infinity only appears with zero value.
  a_ninf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_word.cost_neg_infinite |-> out_word.cost_value == 0)
    else $error("minus infinity with nonzero value");
  // Without general costs a result is never minus infinity.
  a_ninf_gc: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_word.cost_neg_infinite |-> gc_r)
    else $error("minus infinity without general costs");
`endif

endmodule
